// ----- rtl/assert_macros.svh -----
// Assertion helpers, sampled on i_clk, off while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/lcds_pkg.sv -----
package lcds_pkg;

    localparam int MAX_SPLINES = 16;
    localparam int X_W         = 12;
    localparam int CX_W        = 11;
    localparam int KEY_W       = 14;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = $clog2(MAX_SPLINES + 1);

    localparam logic [CX_W-1:0] CENTER_RESET = CX_W'(320);

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
    } t_entry;

    typedef struct packed {
        logic ins;    // parallel insert of the pending key
        logic shift;  // move every entry one place towards the head
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_INSERT,
        ST_DRAIN
    } t_state;

endpackage

// ----- rtl/lcds_ifs.sv -----
interface lcds_in_if;
    import lcds_pkg::*;
    logic             valid;
    logic             ready;
    logic [X_W-1:0]   x_point0;
    logic [X_W-1:0]   x_point1;
    logic [X_W-1:0]   x_point2;
    logic [X_W-1:0]   x_point3;
    logic             final_item;

    modport source (output valid, x_point0, x_point1, x_point2, x_point3, final_item,
                    input ready);
    modport sink   (input valid, x_point0, x_point1, x_point2, x_point3, final_item,
                    output ready);
endinterface

interface lcds_out_if;
    import lcds_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] spline_index;
    logic [KEY_W-1:0] center_gap;
    logic             last_rank;
    logic             overflowed;

    modport source (output valid, spline_index, center_gap, last_rank, overflowed,
                    input ready);
    modport sink   (input valid, spline_index, center_gap, last_rank, overflowed,
                    output ready);
endinterface

// ----- rtl/lcds_key.sv -----
module lcds_key (
    input  logic [lcds_pkg::X_W-1:0]   i_x0,
    input  logic [lcds_pkg::X_W-1:0]   i_x1,
    input  logic [lcds_pkg::X_W-1:0]   i_x2,
    input  logic [lcds_pkg::X_W-1:0]   i_x3,
    input  logic [lcds_pkg::CX_W-1:0]  i_center,
    output logic [lcds_pkg::KEY_W-1:0] o_key
);
    import lcds_pkg::*;

    logic [KEY_W-1:0] sum;
    logic [KEY_W-1:0] c4;

    always_comb begin
        sum = KEY_W'(i_x0) + KEY_W'(i_x1) + KEY_W'(i_x2) + KEY_W'(i_x3);
        c4  = {1'b0, i_center, 2'b00};
        if (sum >= c4) begin
            o_key = sum - c4;
        end else begin
            o_key = c4 - sum;
        end
    end

endmodule

// ----- rtl/lcds_cell.sv -----
module lcds_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lcds_pkg::t_cell_ctl        i_ctl,
    input  logic [lcds_pkg::KEY_W-1:0] i_key,
    input  logic [lcds_pkg::IDX_W-1:0] i_idx,
    input  lcds_pkg::t_entry           i_left,
    input  logic                       i_left_gt,
    input  lcds_pkg::t_entry           i_right,
    output lcds_pkg::t_entry           o_entry,
    output logic                       o_gt
);
    import lcds_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // an empty cell counts as larger than any key
    assign o_gt    = !r_entry.valid || (r_entry.key > i_key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_right;
        end else if (i_ctl.ins && o_gt) begin
            if (i_left_gt) begin
                n_entry = i_left;
            end else begin
                n_entry.valid = 1'b1;
                n_entry.key   = i_key;
                n_entry.idx   = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.key <= n_entry.key;
        r_entry.idx <= n_entry.idx;
    end

endmodule

// ----- rtl/lane_center_distance_sorter_unit.sv -----
// Sorts lane candidate splines by |x0+x1+x2+x3 - 4*center_x|, ascending, ties in arrival
// order, in a row of MAX_SPLINES cells that each hold one entry. Each key is registered,
// then inserted into the cell row in parallel. After a spline marked final_item, the kept
// entries leave from the head cell, one word per cycle while o_out.ready is high, and no
// input is taken until the last one (last_rank) is gone. Splines past MAX_SPLINES in a set
// are dropped and flagged in overflowed on every word of that run. center_x resets to 320;
// write it through i_cfg_we/i_cfg_data only while idle, which the block does not enforce.
module lane_center_distance_sorter_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lcds_pkg::CX_W-1:0] i_cfg_data,
    lcds_in_if.sink                   i_in,
    lcds_out_if.source                o_out
);
    import lcds_pkg::*;
    `include "assert_macros.svh"

    t_state           r_state;
    t_state           n_state;
    logic [CX_W-1:0]  r_center;
    logic [KEY_W-1:0] r_key;
    logic             r_final;
    logic [CNT_W-1:0] r_count;
    logic             r_dropped;
    logic [KEY_W-1:0] in_key;
    logic             full;
    logic             in_acc;
    logic             out_acc;
    t_cell_ctl        ctl;

    t_entry           entries [MAX_SPLINES];
    logic             gts     [MAX_SPLINES];

    lcds_key u_key (
        .i_x0     (i_in.x_point0),
        .i_x1     (i_in.x_point1),
        .i_x2     (i_in.x_point2),
        .i_x3     (i_in.x_point3),
        .i_center (r_center),
        .o_key    (in_key)
    );

    assign full    = (r_count == CNT_W'(MAX_SPLINES));
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    for (genvar g = 0; g < MAX_SPLINES; g++) begin : g_cell
        t_entry left;
        t_entry right;
        logic   left_gt;

        if (g == 0) begin : g_head
            assign left    = '0;
            assign left_gt = 1'b0;
        end else begin : g_mid
            assign left    = entries[g-1];
            assign left_gt = gts[g-1];
        end

        if (g == MAX_SPLINES - 1) begin : g_tail
            assign right = '0;
        end else begin : g_body
            assign right = entries[g+1];
        end

        lcds_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_key     (r_key),
            .i_idx     (r_count[IDX_W-1:0]),
            .i_left    (left),
            .i_left_gt (left_gt),
            .i_right   (right),
            .o_entry   (entries[g]),
            .o_gt      (gts[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                n_state = r_final ? ST_DRAIN : ST_LOAD;
            end
            ST_DRAIN: begin
                if (out_acc && !entries[1].valid) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        ctl         = '0;
        unique case (r_state)
            ST_LOAD:   i_in.ready = 1'b1;
            ST_INSERT: ctl.ins = !full;
            ST_DRAIN: begin
                o_out.valid = entries[0].valid;
                ctl.shift   = out_acc;
            end
            default: ;
        endcase
    end

    assign o_out.spline_index = entries[0].idx;
    assign o_out.center_gap   = entries[0].key;
    assign o_out.last_rank    = !entries[1].valid;
    assign o_out.overflowed   = r_dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_center  <= CENTER_RESET;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_center <= i_cfg_data;
            end
            if (r_state == ST_INSERT) begin
                if (full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (r_state == ST_DRAIN && out_acc && !entries[1].valid) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key   <= in_key;
            r_final <= i_in.final_item;
        end
    end

    `ASSERT_NEVER(a_count_range, r_count > CNT_W'(MAX_SPLINES), "kept count beyond capacity")
    `ASSERT_NEVER(a_head_order, entries[0].valid && entries[1].valid && entries[0].key > entries[1].key, "head cells out of order")
    `ASSERT_CLK(a_last_ends_run, out_acc && o_out.last_rank |=> !o_out.valid && r_count == '0, "run did not end after last rank")
    `ASSERT_CLK(a_drain_nonempty, r_state == ST_DRAIN |-> entries[0].valid, "drain with empty head cell")

endmodule
